// ===== rtl/uvs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Shared types, register codes, sine coefficients and the Q15 multiply helper.
// ----------------------------------------------------------------------------
package uvs_pkg;

  // register indexes on the configuration port (paddr[3:2])
  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_SEGMENTS = 2'd1;
  localparam logic [1:0] REG_RINGS    = 2'd2;

  // pipeline depth of the sine unit
  localparam int unsigned SIN_LAT = 7;

  // Taylor coefficients of sin(pi/2 * t) in Q30, highest degree first
  localparam logic [31:0] SIN_COEF [5] = '{
    32'd172272, 32'd5026997, 32'd85569306, 32'd693598666, 32'd1686629713
  };

  // side information carried through the divider cells
  typedef struct packed {
    logic [17:0] vidx;
    logic        quad;
  } grid_t;

  // side information carried alongside the sine units
  typedef struct packed {
    grid_t       grid;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } vtx_t;

  // (a*b) >> 15, rounded half away from zero
  function automatic logic signed [16:0] mul_q15(input logic signed [16:0] a,
                                                 input logic signed [16:0] b);
    logic signed [33:0] p;
    logic [33:0]        m;
    logic [33:0]        r;
    p = a * b;
    m = p[33] ? 34'(-p) : 34'(p);
    r = (m + 34'd16384) >> 15;
    return p[33] ? -$signed(r[16:0]) : $signed(r[16:0]);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/uvs_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere divider cell
// One restoring division step for both the longitude and latitude fractions;
// cells are chained, each adding one quotient bit per clock when enabled.
// ----------------------------------------------------------------------------
module uvs_div_cell #(
  parameter int SEG_W = 10,
  parameter int RING_W = 9,
  parameter int QW = 18,
  parameter bit FIRST = 1'b0
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  wire                   vld_i,
  input  wire uvs_pkg::grid_t   grid_i,
  input  wire [SEG_W-1:0]       segs_i,
  input  wire [RING_W-1:0]      rings_i,
  input  wire [SEG_W:0]         lon_rem_i,
  input  wire [RING_W:0]        lat_rem_i,
  input  wire [QW-1:0]          lon_q_i,
  input  wire [QW-1:0]          lat_q_i,
  output logic                  vld_o,
  output uvs_pkg::grid_t        grid_o,
  output logic [SEG_W:0]        lon_rem_o,
  output logic [RING_W:0]       lat_rem_o,
  output logic [QW-1:0]         lon_q_o,
  output logic [QW-1:0]         lat_q_o
);
  import uvs_pkg::*;

  logic [SEG_W:0]  lon_t;
  logic [RING_W:0] lat_t;
  logic            lon_ge, lat_ge;
  logic            vld_q;
  grid_t           grid_q;
  logic [SEG_W:0]  lon_rem_q;
  logic [RING_W:0] lat_rem_q;
  logic [QW-1:0]   lon_q_q, lat_q_q;

  // remainder stays below the divisor, so dropping the top bit loses nothing
  assign lon_t  = FIRST ? lon_rem_i : {lon_rem_i[SEG_W-1:0], 1'b0};
  assign lat_t  = FIRST ? lat_rem_i : {lat_rem_i[RING_W-1:0], 1'b0};
  assign lon_ge = lon_t >= {1'b0, segs_i};
  assign lat_ge = lat_t >= {1'b0, rings_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grid_q    <= grid_i;
      lon_rem_q <= lon_ge ? lon_t - {1'b0, segs_i} : lon_t;
      lat_rem_q <= lat_ge ? lat_t - {1'b0, rings_i} : lat_t;
      lon_q_q   <= {lon_q_i[QW-2:0], lon_ge};
      lat_q_q   <= {lat_q_i[QW-2:0], lat_ge};
    end
  end

  assign vld_o     = vld_q;
  assign grid_o    = grid_q;
  assign lon_rem_o = lon_rem_q;
  assign lat_rem_o = lat_rem_q;
  assign lon_q_o   = lon_q_q;
  assign lat_q_o   = lat_q_q;

endmodule
`default_nettype wire

// ===== rtl/uvs_sin.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere sine unit
// Pipelined Q15 sine of a 32-bit turn phase: quarter-wave fold, then a
// Horner polynomial with one multiply per stage.
// ----------------------------------------------------------------------------
module uvs_sin (
  input  wire               clk_i,
  input  wire               en_i,
  input  wire [31:0]        phase_i,
  output logic signed [15:0] sin_o
);
  import uvs_pkg::*;

  logic [30:0]        f_in;
  logic [30:0]        f_q   [6];
  logic               neg_q [6];
  logic [30:0]        u_q   [1:4];
  logic [31:0]        p_q   [2:5];
  logic [61:0]        sq;
  logic [62:0]        fin_prod;
  logic [32:0]        s_val;
  logic [32:0]        r_sum;
  logic [17:0]        r_val;
  logic signed [15:0] mag;
  logic signed [15:0] out_q;

  // fold the odd quadrants back onto the first
  assign f_in = phase_i[30] ? 31'h4000_0000 - {1'b0, phase_i[29:0]}
                            : {1'b0, phase_i[29:0]};
  assign sq   = 62'(f_q[0]) * 62'(f_q[0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q[0]   <= f_in;
      neg_q[0] <= phase_i[31];
      u_q[1]   <= sq[60:30];
      for (int k = 1; k < 6; k++) begin
        f_q[k]   <= f_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
      for (int k = 2; k < 5; k++) begin
        u_q[k] <= u_q[k-1];
      end
    end
  end

  for (genvar k = 2; k < 6; k++) begin : g_horner
    logic [31:0] p_prev;
    logic [62:0] prod;
    if (k == 2) begin : g_first
      assign p_prev = SIN_COEF[0];
    end else begin : g_next
      assign p_prev = p_q[k-1];
    end
    assign prod = 63'(p_prev) * 63'(u_q[k-1]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k] <= SIN_COEF[k-1] - prod[61:30];
      end
    end
  end

  assign fin_prod = 63'(p_q[5]) * 63'(f_q[5]);
  assign s_val    = fin_prod[62:30];
  assign r_sum    = s_val + 33'd16384;
  assign r_val    = r_sum[32:15];
  assign mag      = (r_val > 18'd32767) ? 16'sd32767 : $signed({1'b0, r_val[14:0]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= neg_q[5] ? -mag : mag;
    end
  end

  assign sin_o = out_q;

endmodule
`default_nettype wire

// ===== rtl/uv_sphere_vertex_generator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Turns a longitude/latitude grid coordinate into position, normal, tangent,
// texture coordinates, linear vertex index and a quad-start flag.
// ----------------------------------------------------------------------------
// Takes one vertex per clock and returns one result beat per vertex, in order.
// The path starts at the entry register and runs through the chain of
// divider cells, one quotient bit per cell, that forms the angle and texture
// fractions; then come the 7-stage sine units, the normal multiply and the
// position multiply, which is the output register. A stalled output beat
// holds the whole pipeline.
module uv_sphere_vertex_generator_unit #(
  parameter int MAX_SEGMENTS = 512,
  parameter int MAX_RINGS = 256,
  parameter int ANGLE_BITS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [3:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [9:0]         lon_index_i,
  input  wire  [8:0]         lat_index_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic signed [15:0] tan_x_o,
  output logic signed [15:0] tan_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic [17:0]        vertex_index_o,
  output logic               has_quad_o
);
  import uvs_pkg::*;

  localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int RING_W = $clog2(MAX_RINGS + 1);
  localparam int FRAC   = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
  localparam int QW     = FRAC + 2;

  // configuration registers
  logic [15:0] radius_q;
  logic [9:0]  seg_q;
  logic [8:0]  ring_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      seg_q    <= 10'd32;
      ring_q   <= 9'd16;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RADIUS:   radius_q <= pwdata[15:0];
        REG_SEGMENTS: seg_q    <= pwdata[9:0];
        REG_RINGS:    ring_q   <= pwdata[8:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RADIUS:   prdata = {16'd0, radius_q};
      REG_SEGMENTS: prdata = {22'd0, seg_q};
      REG_RINGS:    prdata = {23'd0, ring_q};
      default:      prdata = 32'd0;
    endcase
  end

  // effective counts and clamped coordinates
  logic [SEG_W-1:0]  segs, lon_c;
  logic [RING_W-1:0] rings, lat_c;

  always_comb begin
    if (seg_q < 10'd3) begin
      segs = SEG_W'(3);
    end else if (32'(seg_q) > 32'(MAX_SEGMENTS)) begin
      segs = SEG_W'(MAX_SEGMENTS);
    end else begin
      segs = SEG_W'(seg_q);
    end
    if (ring_q < 9'd2) begin
      rings = RING_W'(2);
    end else if (32'(ring_q) > 32'(MAX_RINGS)) begin
      rings = RING_W'(MAX_RINGS);
    end else begin
      rings = RING_W'(ring_q);
    end
    lon_c = (32'(lon_index_i) > 32'(segs)) ? segs : SEG_W'(lon_index_i);
    lat_c = (32'(lat_index_i) > 32'(rings)) ? rings : RING_W'(lat_index_i);
  end

  // pipeline advance: move everything unless the output beat is stalled
  logic out_vld_q;
  logic adv;
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  // entry stage
  logic              s0_vld_q;
  grid_t             s0_grid_q;
  logic [SEG_W-1:0]  s0_lon_q;
  logic [RING_W-1:0] s0_lat_q;
  logic [31:0]       vidx_full;

  assign vidx_full = 32'(lat_c) * (32'(segs) + 32'd1) + 32'(lon_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_lon_q       <= lon_c;
      s0_lat_q       <= lat_c;
      s0_grid_q.vidx <= vidx_full[17:0];
      s0_grid_q.quad <= (lon_c < segs) && (lat_c < rings);
    end
  end

  // divider cell chain
  logic              c_vld     [QW+1];
  grid_t             c_grid    [QW+1];
  logic [SEG_W:0]    c_lon_rem [QW+1];
  logic [RING_W:0]   c_lat_rem [QW+1];
  logic [QW-1:0]     c_lon_q   [QW+1];
  logic [QW-1:0]     c_lat_q   [QW+1];

  assign c_vld[0]     = s0_vld_q;
  assign c_grid[0]    = s0_grid_q;
  assign c_lon_rem[0] = {1'b0, s0_lon_q};
  assign c_lat_rem[0] = {1'b0, s0_lat_q};
  assign c_lon_q[0]   = '0;
  assign c_lat_q[0]   = '0;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    uvs_div_cell #(
      .SEG_W  (SEG_W),
      .RING_W (RING_W),
      .QW     (QW),
      .FIRST  (i == 0)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv),
      .vld_i     (c_vld[i]),
      .grid_i    (c_grid[i]),
      .segs_i    (segs),
      .rings_i   (rings),
      .lon_rem_i (c_lon_rem[i]),
      .lat_rem_i (c_lat_rem[i]),
      .lon_q_i   (c_lon_q[i]),
      .lat_q_i   (c_lat_q[i]),
      .vld_o     (c_vld[i+1]),
      .grid_o    (c_grid[i+1]),
      .lon_rem_o (c_lon_rem[i+1]),
      .lat_rem_o (c_lat_rem[i+1]),
      .lon_q_o   (c_lon_q[i+1]),
      .lat_q_o   (c_lat_q[i+1])
    );
  end

  // round the fractions at each needed scale: ((q >> shift) + 1) >> 1
  logic [QW-1:0]         lon_ph_t, lat_ph_t, tex_u_t, tex_v_t;
  logic [ANGLE_BITS-1:0] lon_ph, lat_ph;
  logic [31:0]           lon_phase, lat_phase;
  vtx_t                  vtx_new;

  assign lon_ph_t  = (c_lon_q[QW] >> (FRAC - ANGLE_BITS)) + QW'(1);
  assign lat_ph_t  = (c_lat_q[QW] >> (FRAC - ANGLE_BITS + 1)) + QW'(1);
  assign tex_u_t   = (c_lon_q[QW] >> (FRAC - 16)) + QW'(1);
  assign tex_v_t   = (c_lat_q[QW] >> (FRAC - 16)) + QW'(1);
  // wrap the longitude phase modulo a full turn
  assign lon_ph    = lon_ph_t[ANGLE_BITS:1];
  assign lat_ph    = lat_ph_t[ANGLE_BITS:1];
  assign lon_phase = {lon_ph, {(32 - ANGLE_BITS){1'b0}}};
  assign lat_phase = {lat_ph, {(32 - ANGLE_BITS){1'b0}}};

  assign vtx_new.grid  = c_grid[QW];
  assign vtx_new.tex_u = tex_u_t[17:1];
  assign vtx_new.tex_v = tex_v_t[17:1];

  // trig units
  logic signed [15:0] sin_lon, cos_lon, sin_lat, cos_lat;

  uvs_sin u_sin_lon (
    .clk_i (clk_i), .en_i (adv), .phase_i (lon_phase), .sin_o (sin_lon)
  );
  uvs_sin u_cos_lon (
    .clk_i (clk_i), .en_i (adv), .phase_i (lon_phase + 32'h4000_0000), .sin_o (cos_lon)
  );
  uvs_sin u_sin_lat (
    .clk_i (clk_i), .en_i (adv), .phase_i (lat_phase), .sin_o (sin_lat)
  );
  uvs_sin u_cos_lat (
    .clk_i (clk_i), .en_i (adv), .phase_i (lat_phase + 32'h4000_0000), .sin_o (cos_lat)
  );

  // side data delay matched to the trig units
  logic d_vld_q [SIN_LAT];
  vtx_t d_vtx_q [SIN_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SIN_LAT; k++) begin
        d_vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      d_vld_q[0] <= c_vld[QW];
      for (int k = 1; k < SIN_LAT; k++) begin
        d_vld_q[k] <= d_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_vtx_q[0] <= vtx_new;
      for (int k = 1; k < SIN_LAT; k++) begin
        d_vtx_q[k] <= d_vtx_q[k-1];
      end
    end
  end

  // normal stage
  logic               n_vld_q;
  vtx_t               n_vtx_q;
  logic signed [16:0] nx_q, nz_q;
  logic signed [15:0] ny_q, tx_q, tz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else if (adv) begin
      n_vld_q <= d_vld_q[SIN_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_vtx_q <= d_vtx_q[SIN_LAT-1];
      nx_q    <= mul_q15(17'(cos_lon), 17'(sin_lat));
      nz_q    <= mul_q15(17'(sin_lon), 17'(sin_lat));
      ny_q    <= cos_lat;
      tx_q    <= -sin_lon;
      tz_q    <= cos_lon;
    end
  end

  // position stage, also the output register
  logic signed [16:0] rad_s;
  assign rad_s = $signed({1'b0, radius_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= n_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_o        <= mul_q15(nx_q, rad_s);
      pos_y_o        <= mul_q15(17'(ny_q), rad_s);
      pos_z_o        <= mul_q15(nz_q, rad_s);
      norm_x_o       <= nx_q[15:0];
      norm_y_o       <= ny_q;
      norm_z_o       <= nz_q[15:0];
      tan_x_o        <= tx_q;
      tan_z_o        <= tz_q;
      tex_u_o        <= n_vtx_q.tex_u;
      tex_v_o        <= n_vtx_q.tex_v;
      vertex_index_o <= n_vtx_q.grid.vidx;
      has_quad_o     <= n_vtx_q.grid.quad;
    end
  end

  assign out_valid_o = out_vld_q;

  // a quad never starts on the last column
  a_quad_not_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && has_quad_o |-> tex_u_o != 17'h10000)
    else $error("quad flagged on the last column");

  a_tex_v_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> tex_v_o <= 17'h10000)
    else $error("tex_v beyond one");

  // sine saturates, so trig outputs never reach the negative full scale
  a_norm_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> norm_y_o != 16'sh8000 && tan_z_o != 16'sh8000)
    else $error("cosine out of range");

  a_tan_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> tan_x_o != 16'sh8000)
    else $error("tangent x out of range");

endmodule
`default_nettype wire

// ===== dv/tb_uv_sphere_vertex_generator_unit.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Drives grid coordinates under several radius and count settings, predicts
// every vertex in fixed point and compares each output beat in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic signed [15:0] norm_x, norm_y, norm_z, tan_x, tan_z;
  logic [16:0]        tex_u, tex_v;
  logic [17:0]        vertex_index;
  logic               has_quad;
} vertex_t;

class vertex_scoreboard;
  logic [15:0] radius;
  logic [9:0]  segments;
  logic [8:0]  rings;
  vertex_t     pending[$];
  int          errors;

  function new();
    radius = 16'd256;
    segments = 10'd32;
    rings = 9'd16;
    errors = 0;
  endfunction

  function longint sine_q15(logic [31:0] phase);
    logic [63:0] f, u, p, s, r;
    f = {34'd0, phase[29:0]};
    if (phase[30]) f = 64'h4000_0000 - f;
    u = (f * f) >> 30;
    p = 64'd172272;
    p = 64'd5026997 - ((p * u) >> 30);
    p = 64'd85569306 - ((p * u) >> 30);
    p = 64'd693598666 - ((p * u) >> 30);
    p = 64'd1686629713 - ((p * u) >> 30);
    s = (p * f) >> 30;
    r = (s + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return phase[31] ? -longint'(r) : longint'(r);
  endfunction

  function longint round_q15(longint a, longint b);
    longint prod, mag;
    prod = a * b;
    mag = prod < 0 ? -prod : prod;
    mag = (mag + 16384) >>> 15;
    return prod < 0 ? -mag : mag;
  endfunction

  function void note_vertex(logic [9:0] lon_in, logic [8:0] lat_in);
    longint segs, rngs, lon, lat, lon_ph, lat_ph, sl, cl, sa, ca, nx, ny, nz;
    logic [31:0] lon32, lat32;
    vertex_t v;
    segs = segments < 3 ? 3 : (segments > 512 ? 512 : segments);
    rngs = rings < 2 ? 2 : (rings > 256 ? 256 : rings);
    lon = lon_in > segs ? segs : lon_in;
    lat = lat_in > rngs ? rngs : lat_in;
    lon_ph = ((lon << 16) + segs / 2) / segs;
    lat_ph = ((lat << 15) + rngs / 2) / rngs;
    lon32 = 32'(lon_ph << 16);
    lat32 = 32'(lat_ph << 16);
    sl = sine_q15(lon32);
    cl = sine_q15(lon32 + 32'h4000_0000);
    sa = sine_q15(lat32);
    ca = sine_q15(lat32 + 32'h4000_0000);
    nx = round_q15(cl, sa);
    ny = ca;
    nz = round_q15(sl, sa);
    v.pos_x = 17'(round_q15(nx, radius));
    v.pos_y = 17'(round_q15(ny, radius));
    v.pos_z = 17'(round_q15(nz, radius));
    v.norm_x = 16'(nx);
    v.norm_y = 16'(ny);
    v.norm_z = 16'(nz);
    v.tan_x = 16'(-sl);
    v.tan_z = 16'(cl);
    v.tex_u = 17'(lon_ph);
    v.tex_v = 17'(((lat << 16) + rngs / 2) / rngs);
    v.vertex_index = 18'(lat * (segs + 1) + lon);
    v.has_quad = lon < segs && lat < rngs;
    pending = {pending, v};
  endfunction

  function void check_vertex(vertex_t got);
    vertex_t exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat, actual %p", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got != exp) begin
      $display("%0t: mismatch expected %p actual %p", $time, exp, got);
      errors++;
    end
  endfunction
endclass

module tb_uv_sphere_vertex_generator_unit;
  import uvs_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  logic in_valid_i = 0, in_stall_o;
  logic [9:0] lon_index_i = 0;
  logic [8:0] lat_index_i = 0;
  logic out_valid_o, out_stall_i = 0;
  logic signed [16:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [15:0] norm_x_o, norm_y_o, norm_z_o, tan_x_o, tan_z_o;
  logic [16:0] tex_u_o, tex_v_o;
  logic [17:0] vertex_index_o;
  logic has_quad_o;
  logic calm = 0;

  vertex_scoreboard vertices = new();

  uv_sphere_vertex_generator_unit uut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    vertex_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{pos_x_o, pos_y_o, pos_z_o, norm_x_o, norm_y_o, norm_z_o,
              tan_x_o, tan_z_o, tex_u_o, tex_v_o, vertex_index_o, has_quad_o};
      vertices.check_vertex(got);
    end
  end

  // random back-pressure, none during the calm stretch
  always @(negedge clk_i)
    out_stall_i <= !calm && $urandom_range(99) < 15;

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_RADIUS:   vertices.radius = value[15:0];
      REG_SEGMENTS: vertices.segments = value[9:0];
      REG_RINGS:    vertices.rings = value[8:0];
      default:      ;
    endcase
  endtask

  task automatic send_vertex(logic [9:0] lon, logic [8:0] lat);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1; lon_index_i <= lon; lat_index_i <= lat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    vertices.note_vertex(lon, lat);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (vertices.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      if ($urandom_range(9) == 0) send_vertex(10'($urandom), 9'($urandom));
      else send_vertex(10'($urandom_range(vertices.segments + 1)),
                       9'($urandom_range(vertices.rings + 1)));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    // directed: corners, last column, oversized coordinates
    send_vertex(0, 0);
    send_vertex(32, 0);
    send_vertex(0, 16);
    send_vertex(32, 16);
    send_vertex(10'h3FF, 9'h1FF);
    send_vertex(8, 8);
    send_vertex(16, 4);
    send_vertex(24, 12);
    drain();
    write_reg(REG_SEGMENTS, 0);
    write_reg(REG_RINGS, 0);
    write_reg(REG_RADIUS, 16'hFFFF);
    for (int i = 0; i < 5; i++) send_vertex(10'(i), 9'(i % 4));
    send_vertex(10'h3FF, 9'h1FF);
    drain();
    write_reg(REG_SEGMENTS, 10'h3FF);
    write_reg(REG_RINGS, 9'h1FF);
    write_reg(REG_RADIUS, 0);
    send_vertex(512, 256);
    send_vertex(256, 128);
    send_vertex(511, 255);
    send_vertex(10'h2AA, 9'h155);
    send_vertex(10'h155, 9'h0AA);
    drain();
    write_reg(REG_SEGMENTS, 512);
    write_reg(REG_RINGS, 256);
    write_reg(REG_RADIUS, 16'h1234);
    random_phase(250);
    drain();
    write_reg(REG_SEGMENTS, 3);
    write_reg(REG_RINGS, 2);
    write_reg(REG_RADIUS, 16'h8000);
    random_phase(150);
    drain();
    write_reg(REG_SEGMENTS, 10'($urandom_range(4, 100)));
    write_reg(REG_RINGS, 9'($urandom_range(3, 60)));
    write_reg(REG_RADIUS, 16'($urandom));
    calm = 1;
    random_phase(200);
    calm = 0;
    random_phase(150);
    drain();
    write_reg(REG_SEGMENTS, 10'($urandom));
    write_reg(REG_RINGS, 9'($urandom));
    write_reg(REG_RADIUS, 16'($urandom));
    random_phase(380);
    drain();
    if (vertices.errors == 0 && vertices.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/uvs_pkg.sv
rtl/uvs_div_cell.sv
rtl/uvs_sin.sv
rtl/uv_sphere_vertex_generator_unit.sv
dv/tb_uv_sphere_vertex_generator_unit.sv
